[sv/srnm_pkg.sv]
package srnm_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 20;

    localparam int MODE_W   = 2;
    localparam int BUCKET_W = 20;
    localparam int BW_W     = 16;
    localparam int POWER_W  = 10;
    localparam int TYPE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int RIDX_W   = 6;
    localparam int HITS_W   = 16;
    localparam int EXP_W    = 7;
    localparam int WIN_W    = 4;
    localparam int EXPIRY_W = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_W-1:0]    WINDOW_RESET = 4'd5;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd300;
    localparam logic [HITS_W-1:0]   HITS_MAX     = 16'hFFFF;
    localparam logic [EXP_W-1:0]    EXPIRED_MAX  = 7'd127;

    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRY       = 4'd1;

    typedef enum logic [2:0] {
        ST_MERGED    = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_TICK_DONE = 3'd3,
        ST_READ_DONE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [BW_W-1:0]    bandwidth;
        logic [POWER_W-1:0] power;
        logic [TYPE_W-1:0]  type_code;
        logic [TIME_W-1:0]  first_seen;
        logic [TIME_W-1:0]  latest_seen;
        logic [HITS_W-1:0]  hits;
    } slot_data_t;

    typedef struct packed {
        logic merge;
        logic insert;
        logic rd_valid;
    } scan_flags_t;

endpackage

[sv/signal_registry_nearest_merge_aging.sv]
// Channel  | Handshake          | Carries
// ---------+--------------------+-----------------------------------------------
// s_       | s_valid / s_ready  | mode, bucket, bandwidth, power, type, time, index
// m_       | m_valid / m_ready  | status, index, hits, expired count, slot contents
// cfg_     | cfg_valid/cfg_ready| register index and write data
//
// Each item other than MODE_NONE rotates the slots once around the ring of cells
// past the head unit, one slot per cycle, and a report then writes the chosen
// slot in a write state of its own.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
// A finished result waits in the output register; a stalled m_ready holds the
// block before its next item, and configuration writes are always taken.
module signal_registry_nearest_merge_aging
    import srnm_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [BUCKET_W-1:0]   s_freq_bucket,
    input  logic [BW_W-1:0]       s_bandwidth,
    input  logic [POWER_W-1:0]    s_power_level,
    input  logic [TYPE_W-1:0]     s_type_code,
    input  logic [TIME_W-1:0]     s_now_seconds,
    input  logic [RIDX_W-1:0]     s_read_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [RIDX_W-1:0]     m_entry_index,
    output logic [HITS_W-1:0]     m_hit_count,
    output logic [EXP_W-1:0]      m_expired_count,
    output logic                  m_entry_valid,
    output logic [BUCKET_W-1:0]   m_entry_key,
    output logic [BW_W-1:0]       m_entry_bandwidth,
    output logic [POWER_W-1:0]    m_entry_power,
    output logic [TYPE_W-1:0]     m_entry_type,
    output logic [TIME_W-1:0]     m_entry_first_seen,
    output logic [TIME_W-1:0]     m_entry_last_seen,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [WIN_W-1:0]    window_reg;
    logic [EXPIRY_W-1:0] expiry_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [BW_W-1:0]     bw_reg;
    logic [POWER_W-1:0]  power_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [RIDX_W-1:0]   ridx_reg;

    logic accept;
    logic start;
    logic shift_en;
    logic wr_go;
    logic load_out;

    logic                cell_valid [ENTRIES];
    logic [KEY_BITS-1:0] cell_key   [ENTRIES];
    slot_data_t          cell_data  [ENTRIES];

    logic                wb_valid;
    logic [KEY_BITS-1:0] wb_key;
    slot_data_t          wb_data;
    scan_flags_t         flags;
    logic [IDX_W-1:0]    best_idx;
    logic [HITS_W-1:0]   best_hits;
    logic [IDX_W-1:0]    free_idx;
    logic [CNT_W-1:0]    removed;
    logic [KEY_BITS-1:0] rd_key;
    slot_data_t          rd_data;

    logic [HITS_W-1:0]   merge_hits;
    logic [IDX_W-1:0]    wr_idx;
    slot_data_t          wr_data;

    logic                m_valid_reg;
    status_t             status_reg;
    logic [RIDX_W-1:0]   index_reg;
    logic [HITS_W-1:0]   hits_reg;
    logic [EXP_W-1:0]    expired_reg;
    logic                evalid_reg;
    logic [BUCKET_W-1:0] ekey_reg;
    slot_data_t          edata_reg;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            expiry_reg <= EXPIRY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MATCH_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                REG_EXPIRY:       expiry_reg <= cfg_data[EXPIRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        start      = 1'b0;
        shift_en   = 1'b0;
        wr_go      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_mode != MODE_NONE)) begin
                    start      = 1'b1;
                    step_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                shift_en  = 1'b1;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = (mode_reg == MODE_REPORT) ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE: begin
                wr_go      = flags.merge || flags.insert;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            key_reg   <= KEY_BITS'(s_freq_bucket);
            bw_reg    <= s_bandwidth;
            power_reg <= s_power_level;
            type_reg  <= s_type_code;
            now_reg   <= s_now_seconds;
            ridx_reg  <= s_read_index;
        end
    end

    assign merge_hits = (best_hits == HITS_MAX) ? best_hits : best_hits + HITS_W'(1);
    assign wr_idx     = flags.merge ? best_idx : free_idx;

    always_comb begin
        wr_data.bandwidth   = bw_reg;
        wr_data.power       = power_reg;
        wr_data.type_code   = type_reg;
        wr_data.first_seen  = now_reg;
        wr_data.latest_seen = now_reg;
        wr_data.hits        = flags.merge ? merge_hits : HITS_W'(1);
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic                nb_valid;
        logic [KEY_BITS-1:0] nb_key;
        slot_data_t          nb_data;

        if (i == ENTRIES - 1) begin : g_last
            assign nb_valid = wb_valid;
            assign nb_key   = wb_key;
            assign nb_data  = wb_data;
        end else begin : g_mid
            assign nb_valid = cell_valid[i+1];
            assign nb_key   = cell_key[i+1];
            assign nb_data  = cell_data[i+1];
        end

        srnm_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .in_valid  (nb_valid),
            .in_key    (nb_key),
            .in_data   (nb_data),
            .wr_en     (wr_go && (wr_idx == IDX_W'(i))),
            .wr_insert (!flags.merge),
            .wr_key    (key_reg),
            .wr_data   (wr_data),
            .out_valid (cell_valid[i]),
            .out_key   (cell_key[i]),
            .out_data  (cell_data[i])
        );
    end

    srnm_head #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .step_en   (shift_en),
        .step      (step_reg),
        .mode      (mode_reg),
        .key       (key_reg),
        .now       (now_reg),
        .rd_index  (ridx_reg),
        .window    (window_reg),
        .expiry    (expiry_reg),
        .cur_valid (cell_valid[0]),
        .cur_key   (cell_key[0]),
        .cur_data  (cell_data[0]),
        .wb_valid  (wb_valid),
        .wb_key    (wb_key),
        .wb_data   (wb_data),
        .flags     (flags),
        .best_idx  (best_idx),
        .best_hits (best_hits),
        .free_idx  (free_idx),
        .removed   (removed),
        .rd_key    (rd_key),
        .rd_data   (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            index_reg   <= '0;
            hits_reg    <= '0;
            expired_reg <= '0;
            evalid_reg  <= 1'b0;
            ekey_reg    <= '0;
            edata_reg   <= '0;
            case (mode_reg)
                MODE_REPORT: begin
                    if (flags.merge) begin
                        status_reg <= ST_MERGED;
                        index_reg  <= RIDX_W'(best_idx);
                        hits_reg   <= merge_hits;
                    end else if (flags.insert) begin
                        status_reg <= ST_INSERTED;
                        index_reg  <= RIDX_W'(free_idx);
                        hits_reg   <= HITS_W'(1);
                    end else begin
                        status_reg <= ST_DROPPED;
                    end
                end
                MODE_TICK: begin
                    status_reg <= ST_TICK_DONE;
                    if (32'(removed) > 32'(EXPIRED_MAX)) begin
                        expired_reg <= EXPIRED_MAX;
                    end else begin
                        expired_reg <= EXP_W'(removed);
                    end
                end
                default: begin
                    status_reg <= ST_READ_DONE;
                    index_reg  <= ridx_reg;
                    if (flags.rd_valid) begin
                        hits_reg   <= rd_data.hits;
                        evalid_reg <= 1'b1;
                        ekey_reg   <= BUCKET_W'(rd_key);
                        edata_reg  <= rd_data;
                    end
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_entry_index      = index_reg;
    assign m_hit_count        = hits_reg;
    assign m_expired_count    = expired_reg;
    assign m_entry_valid      = evalid_reg;
    assign m_entry_key        = ekey_reg;
    assign m_entry_bandwidth  = edata_reg.bandwidth;
    assign m_entry_power      = edata_reg.power;
    assign m_entry_type       = edata_reg.type_code;
    assign m_entry_first_seen = edata_reg.first_seen;
    assign m_entry_last_seen  = edata_reg.latest_seen;

endmodule

[sv/srnm_cell.sv]
module srnm_cell
    import srnm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic                in_valid,
    input  logic [KEY_BITS-1:0] in_key,
    input  slot_data_t          in_data,
    input  logic                wr_en,
    input  logic                wr_insert,
    input  logic [KEY_BITS-1:0] wr_key,
    input  slot_data_t          wr_data,
    output logic                out_valid,
    output logic [KEY_BITS-1:0] out_key,
    output slot_data_t          out_data
);

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    slot_data_t          data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= in_valid;
        end else if (wr_en && wr_insert) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg  <= in_key;
            data_reg <= in_data;
        end else if (wr_en) begin
            data_reg.bandwidth   <= wr_data.bandwidth;
            data_reg.power       <= wr_data.power;
            data_reg.type_code   <= wr_data.type_code;
            data_reg.latest_seen <= wr_data.latest_seen;
            data_reg.hits        <= wr_data.hits;
            if (wr_insert) begin
                key_reg             <= wr_key;
                data_reg.first_seen <= wr_data.first_seen;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_data  = data_reg;

endmodule

[sv/srnm_head.sv]
module srnm_head
    import srnm_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = $clog2(ENTRIES),
    localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                step_en,
    input  logic [IDX_W-1:0]    step,
    input  logic [MODE_W-1:0]   mode,
    input  logic [KEY_BITS-1:0] key,
    input  logic [TIME_W-1:0]   now,
    input  logic [RIDX_W-1:0]   rd_index,
    input  logic [WIN_W-1:0]    window,
    input  logic [EXPIRY_W-1:0] expiry,
    input  logic                cur_valid,
    input  logic [KEY_BITS-1:0] cur_key,
    input  slot_data_t          cur_data,
    output logic                wb_valid,
    output logic [KEY_BITS-1:0] wb_key,
    output slot_data_t          wb_data,
    output scan_flags_t         flags,
    output logic [IDX_W-1:0]    best_idx,
    output logic [HITS_W-1:0]   best_hits,
    output logic [IDX_W-1:0]    free_idx,
    output logic [CNT_W-1:0]    removed,
    output logic [KEY_BITS-1:0] rd_key,
    output slot_data_t          rd_data
);

    localparam int CMP_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

    logic                best_found_reg, best_found_next;
    logic [WIN_W-1:0]    best_dist_reg, best_dist_next;
    logic [KEY_BITS-1:0] best_key_reg, best_key_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [HITS_W-1:0]   best_hits_reg, best_hits_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [KEY_BITS-1:0] rd_key_reg, rd_key_next;
    slot_data_t          rd_data_reg, rd_data_next;

    logic [KEY_BITS-1:0] diff;
    logic [WIN_W-1:0]    gap;
    logic                in_window;
    logic                better;
    logic [TIME_W-1:0]   age;
    logic                expire;
    logic                rd_hit;

    always_comb begin
        diff      = (cur_key >= key) ? (cur_key - key) : (key - cur_key);
        in_window = (diff <= KEY_BITS'(window));
        gap       = diff[WIN_W-1:0];
        better    = !best_found_reg || (gap < best_dist_reg) ||
                    ((gap == best_dist_reg) && (cur_key < best_key_reg));
        age       = (now >= cur_data.latest_seen) ? (now - cur_data.latest_seen) : '0;
        expire    = cur_valid && (mode == MODE_TICK) && (age > TIME_W'(expiry));
        rd_hit    = (CMP_W'(step) == CMP_W'(rd_index));
    end

    always_comb begin
        best_found_next = best_found_reg;
        best_dist_next  = best_dist_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        best_hits_next  = best_hits_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        rd_valid_next   = rd_valid_reg;
        rd_key_next     = rd_key_reg;
        rd_data_next    = rd_data_reg;
        if (start) begin
            best_found_next = 1'b0;
            free_found_next = 1'b0;
            removed_next    = '0;
            rd_valid_next   = 1'b0;
        end else if (step_en) begin
            case (mode)
                MODE_REPORT: begin
                    if (cur_valid) begin
                        if (in_window && better) begin
                            best_found_next = 1'b1;
                            best_dist_next  = gap;
                            best_key_next   = cur_key;
                            best_idx_next   = step;
                            best_hits_next  = cur_data.hits;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = step;
                    end
                end
                MODE_TICK: begin
                    if (expire) begin
                        removed_next = removed_reg + CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (rd_hit) begin
                        rd_valid_next = cur_valid;
                        rd_key_next   = cur_key;
                        rd_data_next  = cur_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            removed_reg    <= '0;
        end else begin
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            rd_valid_reg   <= rd_valid_next;
            removed_reg    <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_dist_reg <= best_dist_next;
        best_key_reg  <= best_key_next;
        best_idx_reg  <= best_idx_next;
        best_hits_reg <= best_hits_next;
        free_idx_reg  <= free_idx_next;
        rd_key_reg    <= rd_key_next;
        rd_data_reg   <= rd_data_next;
    end

    assign wb_valid = cur_valid && !expire;
    assign wb_key   = cur_key;
    assign wb_data  = cur_data;

    assign flags.merge    = best_found_reg;
    assign flags.insert   = !best_found_reg && free_found_reg;
    assign flags.rd_valid = rd_valid_reg;
    assign best_idx       = best_idx_reg;
    assign best_hits      = best_hits_reg;
    assign free_idx       = free_idx_reg;
    assign removed        = removed_reg;
    assign rd_key         = rd_key_reg;
    assign rd_data        = rd_data_reg;

endmodule

[sv/srnm_checker.sv]
module srnm_checker
    import srnm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [MODE_W-1:0]   s_mode,
    input logic                m_valid,
    input logic                m_ready,
    input logic [2:0]          m_status,
    input logic [RIDX_W-1:0]   m_entry_index,
    input logic [HITS_W-1:0]   m_hit_count,
    input logic                m_entry_valid,
    input logic [BUCKET_W-1:0] m_entry_key
);

    // A stalled result keeps its status until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    // An accepted item that produces a result takes the block out of idle, so s_ready falls.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode != MODE_NONE) |=> !s_ready)
        else $error("block took an item during a scan");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_TICK_DONE) |-> (m_entry_index == '0) && (m_hit_count == '0))
        else $error("tick result carries slot fields");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DROPPED) |-> (m_entry_index == '0) && (m_hit_count == '0))
        else $error("dropped report carries slot fields");

    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_READ_DONE) |-> !m_entry_valid && (m_entry_key == '0))
        else $error("slot contents shown outside a read");

endmodule

bind signal_registry_nearest_merge_aging srnm_checker u_srnm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_mode        (s_mode),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index),
    .m_hit_count   (m_hit_count),
    .m_entry_valid (m_entry_valid),
    .m_entry_key   (m_entry_key)
);
